>>> design/atlb_pkg.sv
// ============================================================================
// atlb_pkg
// Shared types and command codes for the associative TLB with LRU eviction.
// ============================================================================
`default_nettype none

package atlb_pkg;

    // Command codes
    localparam logic [2:0] CMD_LOOKUP    = 3'd0;
    localparam logic [2:0] CMD_INSERT    = 3'd1;
    localparam logic [2:0] CMD_FLUSH_ALL = 3'd2;
    localparam logic [2:0] CMD_FLUSH_ONE = 3'd3;
    localparam logic [2:0] CMD_CLR_CNT   = 3'd4;

    // Input item
    typedef struct packed {
        logic [2:0]  cmd;
        logic [7:0]  virt_page;
        logic [7:0]  phys_frame_in;
        logic        dirty_in;
        logic [7:0]  perm_in;
        logic [31:0] now_tick;
    } tlb_req_t;

    // Result item
    typedef struct packed {
        logic        hit;
        logic [7:0]  phys_frame_out;
        logic        dirty_out;
        logic [7:0]  perm_out;
        logic [31:0] hit_total;
        logic [31:0] miss_total;
    } tlb_rsp_t;

    // One stored entry (valid bit kept apart in flip-flops)
    typedef struct packed {
        logic [7:0]  virt_page;
        logic [7:0]  phys_frame;
        logic        dirty;
        logic [7:0]  perm;
        logic [31:0] last_used;
    } tlb_line_t;

endpackage

`default_nettype wire

>>> design/atlb_mem.sv
// ============================================================================
// atlb_mem
// Entry storage: one write port, one read port with registered read data.
// ============================================================================
`default_nettype none

module atlb_mem #(
    parameter int TLB_ENTRIES = 16
) (
    input  wire logic                             clk,
    input  wire logic                             wr_en,
    input  wire logic [$clog2(TLB_ENTRIES)-1:0]   wr_addr,
    input  wire atlb_pkg::tlb_line_t              wr_data,
    input  wire logic                             rd_en,
    input  wire logic [$clog2(TLB_ENTRIES)-1:0]   rd_addr,
    output atlb_pkg::tlb_line_t                   rd_data
);

    atlb_pkg::tlb_line_t mem [TLB_ENTRIES];
    atlb_pkg::tlb_line_t rd_data_reg;

    // write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // read port
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

>>> design/atlb_scan.sv
// ============================================================================
// atlb_scan
// Shared compare unit: one entry per beat, tracks first match, first free
// slot and least-recent victim over a full pass.
// ============================================================================
`default_nettype none

module atlb_scan #(
    parameter int TLB_ENTRIES = 16
) (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             clear,
    input  wire logic                             beat_vld,
    input  wire logic [$clog2(TLB_ENTRIES)-1:0]   beat_idx,
    input  wire logic                             beat_entry_vld,
    input  wire atlb_pkg::tlb_line_t              beat_entry,
    input  wire logic [7:0]                       page,
    output logic                                  page_hit,
    output logic                                  match_found,
    output logic [$clog2(TLB_ENTRIES)-1:0]        match_idx,
    output atlb_pkg::tlb_line_t                   match_entry,
    output logic                                  free_found,
    output logic [$clog2(TLB_ENTRIES)-1:0]        free_idx,
    output logic [$clog2(TLB_ENTRIES)-1:0]        victim_idx
);

    localparam int IDX_W = $clog2(TLB_ENTRIES);

    logic                  match_found_reg;
    logic [IDX_W-1:0]      match_idx_reg;
    atlb_pkg::tlb_line_t   match_entry_reg;
    logic                  free_found_reg;
    logic [IDX_W-1:0]      free_idx_reg;
    logic [IDX_W-1:0]      victim_idx_reg;
    logic [31:0]           victim_ts_reg;
    logic                  older;

    // page compare and timestamp compare for this beat
    assign page_hit = beat_vld && beat_entry_vld && (beat_entry.virt_page == page);
    assign older    = (beat_idx == '0) || (beat_entry.last_used < victim_ts_reg);

    // search flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            match_found_reg <= 1'b0;
            free_found_reg  <= 1'b0;
        end
        else if (clear)
        begin
            match_found_reg <= 1'b0;
            free_found_reg  <= 1'b0;
        end
        else if (beat_vld)
        begin
            if (page_hit)
            begin
                match_found_reg <= 1'b1;
            end
            if (!beat_entry_vld)
            begin
                free_found_reg <= 1'b1;
            end
        end
    end

    // captured indexes and data; first match and first free slot win
    always_ff @(posedge clk)
    begin
        if (beat_vld && !clear)
        begin
            if (page_hit && !match_found_reg)
            begin
                match_idx_reg   <= beat_idx;
                match_entry_reg <= beat_entry;
            end
            if (!beat_entry_vld && !free_found_reg)
            begin
                free_idx_reg <= beat_idx;
            end
            // strict less-than keeps the lowest index on a tie
            if (older)
            begin
                victim_idx_reg <= beat_idx;
                victim_ts_reg  <= beat_entry.last_used;
            end
        end
    end

    assign match_found = match_found_reg;
    assign match_idx   = match_idx_reg;
    assign match_entry = match_entry_reg;
    assign free_found  = free_found_reg;
    assign free_idx    = free_idx_reg;
    assign victim_idx  = victim_idx_reg;

endmodule

`default_nettype wire

>>> design/assoc_tlb_lru.sv
// ============================================================================
// assoc_tlb_lru
// Fully associative TLB with LRU replacement and hit/miss counters.
// ============================================================================
// Usage:
//   Raise start with a request item while busy is low; the item is taken at
//   that clock edge and busy rises on the next cycle. Exactly one result item
//   follows on result, marked by done for a single cycle; the receiver cannot
//   stall, so it must sample result whenever done is high.
//   Lookup, insert and flush-one make one pass over the entry memory, one
//   entry per cycle through the shared compare unit, then pass through a
//   drain state and a write-back state before done. Flush-all, counter
//   reset and unused codes skip the pass and go straight to write-back.
//   The memory read port (one entry a cycle) sets the pass length. A new
//   item may be started in the cycle done is high.
//   Reset clears all valid bits and both counters at once; entry fields
//   live in memory and never affect a result while their valid bit is low.
// ============================================================================
`default_nettype none

module assoc_tlb_lru #(
    parameter int TLB_ENTRIES = 16
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                start,
    input  wire atlb_pkg::tlb_req_t  request,
    output logic                     busy,
    output logic                     done,
    output atlb_pkg::tlb_rsp_t       result
);

    localparam int IDX_W = $clog2(TLB_ENTRIES);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TLB_ENTRIES - 1);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN,
        ST_WRITE
    } state_t;

    state_t                 state_reg;
    atlb_pkg::tlb_req_t     req_reg;
    logic [IDX_W-1:0]       rd_idx_reg;
    logic                   beat_vld_reg;
    logic [IDX_W-1:0]       beat_idx_reg;
    logic [TLB_ENTRIES-1:0] valid_reg;
    logic [31:0]            hit_cnt_reg;
    logic [31:0]            miss_cnt_reg;
    logic                   done_reg;
    atlb_pkg::tlb_rsp_t     result_reg;

    logic                   accept;
    logic                   needs_scan;
    logic                   rd_en;
    atlb_pkg::tlb_line_t    rd_data;
    logic                   wr_en;
    logic [IDX_W-1:0]       wr_addr;
    atlb_pkg::tlb_line_t    wr_data;
    logic                   page_hit;
    logic                   match_found;
    logic [IDX_W-1:0]       match_idx;
    atlb_pkg::tlb_line_t    match_entry;
    logic                   free_found;
    logic [IDX_W-1:0]       free_idx;
    logic [IDX_W-1:0]       victim_idx;
    logic                   is_lookup;
    logic                   is_insert;
    logic                   lookup_hit;
    logic [IDX_W-1:0]       ins_idx;

    assign accept     = start && (state_reg == ST_IDLE);
    assign busy       = (state_reg != ST_IDLE);
    assign needs_scan = (request.cmd == atlb_pkg::CMD_LOOKUP) ||
                        (request.cmd == atlb_pkg::CMD_INSERT) ||
                        (request.cmd == atlb_pkg::CMD_FLUSH_ONE);
    assign rd_en      = (state_reg == ST_SCAN);

    // command decode for the write-back cycle
    assign is_lookup  = (req_reg.cmd == atlb_pkg::CMD_LOOKUP);
    assign is_insert  = (req_reg.cmd == atlb_pkg::CMD_INSERT);
    assign lookup_hit = is_lookup && match_found;
    assign ins_idx    = match_found ? match_idx : (free_found ? free_idx : victim_idx);

    // write-back: refresh timestamp on a hit, or store the inserted entry
    always_comb
    begin
        wr_en   = 1'b0;
        wr_addr = ins_idx;
        wr_data = '{virt_page:  req_reg.virt_page,
                    phys_frame: req_reg.phys_frame_in,
                    dirty:      req_reg.dirty_in,
                    perm:       req_reg.perm_in,
                    last_used:  req_reg.now_tick};
        if (state_reg == ST_WRITE)
        begin
            if (is_insert)
            begin
                wr_en = 1'b1;
            end
            else if (lookup_hit)
            begin
                wr_en             = 1'b1;
                wr_addr           = match_idx;
                wr_data           = match_entry;
                wr_data.last_used = req_reg.now_tick;
            end
        end
    end

    atlb_mem #(
        .TLB_ENTRIES (TLB_ENTRIES)
    ) u_mem (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_idx_reg),
        .rd_data (rd_data)
    );

    atlb_scan #(
        .TLB_ENTRIES (TLB_ENTRIES)
    ) u_scan (
        .clk            (clk),
        .rst_n          (rst_n),
        .clear          (accept),
        .beat_vld       (beat_vld_reg),
        .beat_idx       (beat_idx_reg),
        .beat_entry_vld (valid_reg[beat_idx_reg]),
        .beat_entry     (rd_data),
        .page           (req_reg.virt_page),
        .page_hit       (page_hit),
        .match_found    (match_found),
        .match_idx      (match_idx),
        .match_entry    (match_entry),
        .free_found     (free_found),
        .free_idx       (free_idx),
        .victim_idx     (victim_idx)
    );

    // sequencer, valid bits, counters and result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            rd_idx_reg   <= '0;
            beat_vld_reg <= 1'b0;
            beat_idx_reg <= '0;
            valid_reg    <= '0;
            hit_cnt_reg  <= '0;
            miss_cnt_reg <= '0;
            done_reg     <= 1'b0;
        end
        else
        begin
            done_reg     <= 1'b0;
            beat_vld_reg <= rd_en;
            beat_idx_reg <= rd_idx_reg;

            // flush-one clears matches as the pass goes by
            if (page_hit && (req_reg.cmd == atlb_pkg::CMD_FLUSH_ONE))
            begin
                valid_reg[beat_idx_reg] <= 1'b0;
            end

            case (state_reg)
                ST_IDLE:
                begin
                    rd_idx_reg <= '0;
                    if (accept)
                    begin
                        state_reg <= needs_scan ? ST_SCAN : ST_WRITE;
                    end
                end
                ST_SCAN:
                begin
                    rd_idx_reg <= rd_idx_reg + 1'b1;
                    if (rd_idx_reg == LAST_IDX)
                    begin
                        state_reg <= ST_DRAIN;
                    end
                end
                ST_DRAIN:
                begin
                    state_reg <= ST_WRITE;
                end
                ST_WRITE:
                begin
                    state_reg <= ST_IDLE;
                    done_reg  <= 1'b1;
                    case (req_reg.cmd)
                        atlb_pkg::CMD_LOOKUP:
                        begin
                            if (match_found)
                            begin
                                hit_cnt_reg <= hit_cnt_reg + 32'd1;
                            end
                            else
                            begin
                                miss_cnt_reg <= miss_cnt_reg + 32'd1;
                            end
                        end
                        atlb_pkg::CMD_INSERT:
                        begin
                            valid_reg[ins_idx] <= 1'b1;
                        end
                        atlb_pkg::CMD_FLUSH_ALL:
                        begin
                            valid_reg <= '0;
                        end
                        atlb_pkg::CMD_CLR_CNT:
                        begin
                            hit_cnt_reg  <= '0;
                            miss_cnt_reg <= '0;
                        end
                        default:
                        begin
                        end
                    endcase
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    // request capture
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            req_reg <= request;
        end
    end

    // result payload, counters as they stand after this item
    always_ff @(posedge clk)
    begin
        if (state_reg == ST_WRITE)
        begin
            result_reg.hit            <= lookup_hit;
            result_reg.phys_frame_out <= lookup_hit ? match_entry.phys_frame : 8'd0;
            result_reg.dirty_out      <= lookup_hit ? match_entry.dirty : 1'b0;
            result_reg.perm_out       <= lookup_hit ? match_entry.perm : 8'd0;
            if (req_reg.cmd == atlb_pkg::CMD_CLR_CNT)
            begin
                result_reg.hit_total  <= '0;
                result_reg.miss_total <= '0;
            end
            else
            begin
                result_reg.hit_total  <= hit_cnt_reg + {31'd0, lookup_hit};
                result_reg.miss_total <= miss_cnt_reg +
                                         {31'd0, is_lookup && !match_found};
            end
        end
    end

    assign done   = done_reg;
    assign result = result_reg;

endmodule

`default_nettype wire
